// File: rtl/pcgr_pkg.sv
// Package for the path capacity greedy reservation block.
// Holds the path size, derived widths, controller states and the ring control struct.
// Depends on nothing; every other file uses it by scoped names.
`default_nettype none

package pcgr_pkg;

	localparam int NUM_STOPS = 2048;
	localparam int STOP_W    = 11;
	localparam int AMT_W     = 16;
	localparam int LOAD_W    = 16;
	localparam int TOTAL_W   = 32;
	localparam int SEG_W     = $clog2(NUM_STOPS);
	localparam int CNT_W     = $clog2(NUM_STOPS + 1);
	localparam int CLIP_W    = (CNT_W > STOP_W) ? CNT_W : STOP_W;

	localparam int APB_DW    = 32;
	localparam int APB_AW    = 3;
	localparam int REG_CAPACITY = 0;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_GRANT  = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	typedef struct packed {
		logic              shift;
		logic [LOAD_W-1:0] feed;
	} ring_ctl_t;

endpackage

`default_nettype wire

// File: rtl/pcgr_if.sv
// Valid/ready channel interfaces for requests and grant results.
// Depends on pcgr_pkg for the field widths.
`default_nettype none

interface pcgr_req_if;
	logic                          valid;
	logic                          ready;
	logic [pcgr_pkg::STOP_W-1:0]   start_stop;
	logic [pcgr_pkg::STOP_W-1:0]   end_stop;
	logic [pcgr_pkg::AMT_W-1:0]    amount;

	modport source (output valid, start_stop, end_stop, amount, input ready);
	modport sink   (input valid, start_stop, end_stop, amount, output ready);
endinterface

interface pcgr_res_if;
	logic                          valid;
	logic                          ready;
	logic [pcgr_pkg::AMT_W-1:0]    granted;
	logic [pcgr_pkg::TOTAL_W-1:0]  total_granted;

	modport source (output valid, granted, total_granted, input ready);
	modport sink   (input valid, granted, total_granted, output ready);
endinterface

`default_nettype wire

// File: rtl/pcgr_cell.sv
// One ring cell: holds the committed load of one path segment.
// Depends on pcgr_pkg; shifts its load to the next cell on each ring step.
`default_nettype none

module pcgr_cell (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        shift,
	input  wire logic [pcgr_pkg::LOAD_W-1:0] din,
	output logic      [pcgr_pkg::LOAD_W-1:0] dout
);

	logic [pcgr_pkg::LOAD_W-1:0] load_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= '0;
		end else if (shift) begin
			load_q <= din;
		end
	end

	assign dout = load_q;

endmodule

`default_nettype wire

// File: rtl/pcgr_ctrl.sv
// Sequencer at the head of the ring: takes requests, finds the peak load, updates loads.
// Depends on pcgr_pkg and the channel interfaces in pcgr_if.
`default_nettype none

module pcgr_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	pcgr_req_if.sink                          req,
	pcgr_res_if.source                        res,
	input  wire logic [pcgr_pkg::AMT_W-1:0]   capacity,
	input  wire logic [pcgr_pkg::LOAD_W-1:0]  head_load,
	output pcgr_pkg::ring_ctl_t               ring
);

	localparam int CW = pcgr_pkg::CLIP_W;

	pcgr_pkg::state_t               state_q;
	logic [pcgr_pkg::SEG_W-1:0]     cnt_q;
	logic [CW-1:0]                  from_q;
	logic [CW-1:0]                  to_q;
	logic                           empty_q;
	logic [pcgr_pkg::AMT_W-1:0]     amt_q;
	logic [pcgr_pkg::LOAD_W-1:0]    peak_q;
	logic [pcgr_pkg::AMT_W-1:0]     grant_q;
	logic [pcgr_pkg::AMT_W-1:0]     out_grant_q;
	logic                           out_vld_q;
	logic [pcgr_pkg::TOTAL_W-1:0]   sum_q;

	logic [CW-1:0]                  from_c;
	logic [CW-1:0]                  to_c;
	logic [CW-1:0]                  seg_c;
	logic                           in_route;
	logic                           last_step;
	logic                           acc;
	logic                           ld_out;
	logic [pcgr_pkg::AMT_W-1:0]     room_c;
	logic [pcgr_pkg::AMT_W-1:0]     grant_c;
	logic [pcgr_pkg::LOAD_W:0]      load_sum;
	logic [pcgr_pkg::TOTAL_W:0]     total_sum;

	assign from_c = (CW'(req.start_stop) > CW'(pcgr_pkg::NUM_STOPS)) ?
		CW'(pcgr_pkg::NUM_STOPS) : CW'(req.start_stop);
	assign to_c = (CW'(req.end_stop) > CW'(pcgr_pkg::NUM_STOPS)) ?
		CW'(pcgr_pkg::NUM_STOPS) : CW'(req.end_stop);

	assign seg_c     = CW'(pcgr_pkg::SEG_W'(pcgr_pkg::NUM_STOPS - 1) - cnt_q);
	assign in_route  = (seg_c >= from_q) && (seg_c < to_q);
	assign last_step = (cnt_q == pcgr_pkg::SEG_W'(pcgr_pkg::NUM_STOPS - 1));

	assign req.ready = (state_q == pcgr_pkg::ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign ld_out    = (state_q == pcgr_pkg::ST_DONE) && (!out_vld_q || res.ready);

	assign room_c  = (peak_q >= capacity) ? '0 : capacity - peak_q;
	assign grant_c = (amt_q < room_c) ? amt_q : room_c;

	assign load_sum  = {1'b0, head_load} + {1'b0, grant_q};
	assign total_sum = {1'b0, sum_q} + (pcgr_pkg::TOTAL_W + 1)'(grant_q);

	always_comb begin
		ring.shift = (state_q == pcgr_pkg::ST_SCAN) || (state_q == pcgr_pkg::ST_UPDATE);
		ring.feed  = head_load;
		if ((state_q == pcgr_pkg::ST_UPDATE) && in_route) begin
			ring.feed = load_sum[pcgr_pkg::LOAD_W] ? '1 : load_sum[pcgr_pkg::LOAD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcgr_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				pcgr_pkg::ST_IDLE: begin
					cnt_q <= '0;
					if (acc) begin
						state_q <= (from_c < to_c) ? pcgr_pkg::ST_SCAN : pcgr_pkg::ST_GRANT;
					end
				end
				pcgr_pkg::ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step) begin
						state_q <= pcgr_pkg::ST_GRANT;
					end
				end
				pcgr_pkg::ST_GRANT: begin
					cnt_q   <= '0;
					state_q <= empty_q ? pcgr_pkg::ST_DONE : pcgr_pkg::ST_UPDATE;
				end
				pcgr_pkg::ST_UPDATE: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step) begin
						state_q <= pcgr_pkg::ST_DONE;
					end
				end
				pcgr_pkg::ST_DONE: begin
					if (ld_out) begin
						state_q <= pcgr_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= pcgr_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			from_q  <= from_c;
			to_q    <= to_c;
			empty_q <= !(from_c < to_c);
			amt_q   <= req.amount;
			peak_q  <= '0;
		end else if ((state_q == pcgr_pkg::ST_SCAN) && in_route && (head_load > peak_q)) begin
			peak_q <= head_load;
		end
		if (state_q == pcgr_pkg::ST_GRANT) begin
			grant_q <= grant_c;
		end
		if (ld_out) begin
			out_grant_q <= grant_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			sum_q     <= '0;
		end else begin
			if (ld_out) begin
				out_vld_q <= 1'b1;
				sum_q     <= total_sum[pcgr_pkg::TOTAL_W] ? '1 :
					total_sum[pcgr_pkg::TOTAL_W-1:0];
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign res.valid         = out_vld_q;
	assign res.granted       = out_grant_q;
	assign res.total_granted = sum_q;

	a_grant_cap: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out |-> (grant_q <= capacity))
		else $error("grant exceeds capacity");

	a_sum_mono: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (sum_q >= $past(sum_q)))
		else $error("running total decreased");

	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (from_c < to_c)) |=> ((state_q == pcgr_pkg::ST_SCAN) && (cnt_q == '0)))
		else $error("scan did not start at the ring head");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !res.ready) |=> $stable(out_grant_q))
		else $error("pending grant changed");

endmodule

`default_nettype wire

// File: rtl/path_capacity_greedy_reserve_unit.sv
// Top level of the path capacity greedy reservation block.
// Depends on pcgr_pkg, pcgr_if, pcgr_cell and pcgr_ctrl; holds the APB register and the ring.
//
// channel   dir   transfer                         payload
// req       in    req.valid && req.ready           start_stop, end_stop, amount
// res       out   res.valid && res.ready           granted, total_granted
// apb       in    psel && penable && pwrite        capacity at byte addresses 0 to 3
//
// For a request with a non-empty route, the segment loads circulate once around the ring
// of cells to find the peak and once more to add the grant. A request with an empty route
// skips both passes. Reset clears all loads, the total and capacity at once. A waiting
// result does not block the next request; only its final step waits for the result
// register to free up.
`default_nettype none

module path_capacity_greedy_reserve_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	pcgr_req_if.sink                           req,
	pcgr_res_if.source                         res,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [pcgr_pkg::APB_AW-1:0]   paddr,
	input  wire logic [pcgr_pkg::APB_DW-1:0]   pwdata,
	output logic      [pcgr_pkg::APB_DW-1:0]   prdata,
	output logic                               pready
);

	logic [pcgr_pkg::AMT_W-1:0]  capacity_q;
	logic [pcgr_pkg::LOAD_W-1:0] chain [pcgr_pkg::NUM_STOPS];
	pcgr_pkg::ring_ctl_t         ring;
	logic                        sel_cap;

	assign pready  = 1'b1;
	assign sel_cap = (paddr[pcgr_pkg::APB_AW-1] == 1'(pcgr_pkg::REG_CAPACITY));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
		end else if (psel && penable && pwrite && pready && sel_cap) begin
			capacity_q <= pwdata[pcgr_pkg::AMT_W-1:0];
		end
	end

	assign prdata = sel_cap ? pcgr_pkg::APB_DW'(capacity_q) : '0;

	for (genvar i = 0; i < pcgr_pkg::NUM_STOPS; i++) begin : g_cell
		if (i == 0) begin : g_head
			pcgr_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (ring.shift),
				.din    (ring.feed),
				.dout   (chain[i])
			);
		end else begin : g_body
			pcgr_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (ring.shift),
				.din    (chain[i-1]),
				.dout   (chain[i])
			);
		end
	end

	pcgr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res       (res),
		.capacity  (capacity_q),
		.head_load (chain[pcgr_pkg::NUM_STOPS-1]),
		.ring      (ring)
	);

endmodule

`default_nettype wire
